// ===== hdl/olt_pkg.sv =====
// Shared types and constants for the order lifecycle tracker.
package olt_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_LOCAL  = 3'd1;
    localparam logic [2:0] OP_REPORT = 3'd2;
    localparam logic [2:0] OP_TRADE  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [2:0] EV_RISK_ACC  = 3'd0;
    localparam logic [2:0] EV_RISK_REJ  = 3'd1;
    localparam logic [2:0] EV_SUB_REJ   = 3'd2;
    localparam logic [2:0] EV_SUB_UNK   = 3'd3;
    localparam logic [2:0] EV_SUBMITTED = 3'd4;
    localparam logic [2:0] EV_CXL_REQ   = 3'd5;

    localparam logic [2:0] RPT_ACCEPTED = 3'd0;
    localparam logic [2:0] RPT_REJECTED = 3'd1;
    localparam logic [2:0] RPT_PARTIAL  = 3'd2;
    localparam logic [2:0] RPT_FILLED   = 3'd3;
    localparam logic [2:0] RPT_CANCELED = 3'd4;
    localparam logic [2:0] RPT_CXL_REJ  = 3'd5;

    localparam logic [2:0] RC_APPLIED  = 3'd0;
    localparam logic [2:0] RC_DUP      = 3'd1;
    localparam logic [2:0] RC_CONFLICT = 3'd2;
    localparam logic [2:0] RC_CAPACITY = 3'd3;
    localparam logic [2:0] RC_UNKNOWN  = 3'd4;
    localparam logic [2:0] RC_STALE    = 3'd5;

    localparam logic [3:0] ST_CREATED   = 4'd0;
    localparam logic [3:0] ST_RISK_ACC  = 4'd1;
    localparam logic [3:0] ST_RISK_REJ  = 4'd2;
    localparam logic [3:0] ST_SUB_REJ   = 4'd3;
    localparam logic [3:0] ST_SUB_UNK   = 4'd4;
    localparam logic [3:0] ST_SUBMITTED = 4'd5;
    localparam logic [3:0] ST_ACCEPTED  = 4'd6;
    localparam logic [3:0] ST_PARTIAL   = 4'd7;
    localparam logic [3:0] ST_CXL_REQ   = 4'd8;
    localparam logic [3:0] ST_CANCELED  = 4'd9;
    localparam logic [3:0] ST_FILLED    = 4'd10;
    localparam logic [3:0] ST_REJECTED  = 4'd11;

    typedef struct packed {
        logic        occupied;
        logic [63:0] order_id;
        logic [30:0] quantity;
        logic [3:0]  state;
        logic [30:0] filled;
        logic        cancel_ack;
        logic        reconcile;
    } t_slot;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] order_id;
        logic [31:0] quantity;
        logic        instrument_present;
        logic [2:0]  local_event;
        logic [2:0]  report_type;
        logic [31:0] cum_fill;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        state_moved;
        logic        fill_moved;
        logic        reconcile_needed;
        logic        order_found;
        logic [3:0]  order_state;
        logic [30:0] order_qty;
        logic [30:0] filled_quantity;
        logic        cancel_ack;
        logic        order_reconcile;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic              load;
        logic              rd;
        logic [SLOT_W-1:0] addr;
        logic              eval;
        logic              clear;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic              occupied;
        logic              id_match;
        logic [SLOT_W-1:0] home;
        logic              is_probe_op;
        logic              create_bad;
    } t_status;

    function automatic logic closed_state(input logic [3:0] s);
        return (s == ST_RISK_REJ) || (s == ST_SUB_REJ) || (s == ST_SUB_UNK) ||
               (s == ST_CANCELED) || (s == ST_FILLED) || (s == ST_REJECTED);
    endfunction

endpackage

// ===== hdl/order_lifecycle_tracker.sv =====
// Top level of the order lifecycle tracker.
// After reset the block clears its slot memory one slot per cycle, so s_axis_tready
// stays low until every slot is cleared. A beat is looked up by linear probing from the
// slot given by the low order_id bits; each probe is a read and a compare of the
// single-port slot memory. The controller moves from S_READ through S_CHECK to S_EVAL,
// repeating S_READ and S_CHECK for each further probe, and S_EVAL writes the result
// register once the output is free. Beats that need no lookup (trades, malformed creates
// and unused opcodes) go from S_READ straight to S_EVAL. Items are taken one at a time;
// a finished result waits in the output register while the next beat is accepted and
// probed. The account flag is sticky until reset.
module order_lifecycle_tracker import olt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], order_id[66:3], quantity[98:67], instrument_present[99],
    // local_event[102:100], report_type[105:103], cum_fill[137:106]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_code[2:0], state_moved[3], fill_moved[4], position_changed[5],
    // reconcile_needed[6], order_found[7], order_state[11:8],
    // order_qty[42:12], filled_quantity[73:43], cxl_ack[74],
    // order_reconcile[75], account_reconcile[76]
    output logic [79:0]  m_axis_tdata
);

    t_item   w_item;
    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_found;
    logic    w_have;
    logic    w_acct;
    logic    w_busy;

    assign w_item.opcode             = s_axis_tdata[2:0];
    assign w_item.order_id           = s_axis_tdata[66:3];
    assign w_item.quantity           = s_axis_tdata[98:67];
    assign w_item.instrument_present = s_axis_tdata[99];
    assign w_item.local_event        = s_axis_tdata[102:100];
    assign w_item.report_type        = s_axis_tdata[105:103];
    assign w_item.cum_fill           = s_axis_tdata[137:106];

    assign w_busy = m_axis_tvalid && !m_axis_tready;

    olt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_busy  (w_busy),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_found     (w_found),
        .o_have_slot (w_have)
    );

    olt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_found     (w_found),
        .i_have_slot (w_have),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result),
        .o_account   (w_acct)
    );

    assign m_axis_tdata = {3'b000, w_acct, w_result.order_reconcile, w_result.cancel_ack,
                           w_result.filled_quantity, w_result.order_qty,
                           w_result.order_state, w_result.order_found,
                           w_result.reconcile_needed, 1'b0, w_result.fill_moved,
                           w_result.state_moved, w_result.result_code};

endmodule

// ===== hdl/olt_ctrl.sv =====
// Probe sequencer for the order lifecycle tracker.
module olt_ctrl import olt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_busy,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_found,
    output logic    o_have_slot
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_EVAL} t_state;

    t_state            r_state;
    logic [SLOT_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    logic              r_found;
    logic              r_have;
    logic              r_first;

    logic [SLOT_W-1:0] w_next;
    assign w_next = (r_addr == SLOT_W'(SLOTS - 1)) ? '0 : r_addr + SLOT_W'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_found     = r_found;
    assign o_have_slot = r_have;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd    = (r_state == S_READ);
        o_cmd.addr  = r_addr;
        o_cmd.eval  = (r_state == S_EVAL) && !i_out_busy;
        o_cmd.clear = (r_state == S_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_have  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_addr <= w_next;
                    if (r_addr == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_READ;
                        r_first <= 1'b1;
                        r_count <= '0;
                        r_found <= 1'b0;
                        r_have  <= 1'b0;
                    end
                end
                S_READ: begin
                    if (r_first) begin
                        r_addr <= i_status.home;
                        if (!i_status.is_probe_op) begin
                            r_state <= S_EVAL;
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                    r_first <= 1'b0;
                end
                S_CHECK: begin
                    if (!i_status.occupied) begin
                        r_have  <= 1'b1;
                        r_state <= S_EVAL;
                    end else if (i_status.id_match) begin
                        r_found <= 1'b1;
                        r_have  <= 1'b1;
                        r_state <= S_EVAL;
                    end else if (r_count == CNT_W'(SLOTS - 1)) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_addr  <= w_next;
                        r_state <= S_READ;
                    end
                end
                S_EVAL: begin
                    if (!i_out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/olt_dp.sv =====
// Slot memory, order rules and result register for the order lifecycle tracker.
module olt_dp import olt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    input  logic    i_found,
    input  logic    i_have_slot,
    output t_status o_status,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_result,
    output logic    o_account
);

    t_slot             mem [SLOTS];
    t_slot             r_rd;
    t_item             r_item;
    logic              r_account;
    logic              r_valid;
    t_result           r_result;

    logic              w_we;
    t_slot             w_wdata;
    t_result           n_result;
    logic              n_acct;

    assign o_status.occupied    = r_rd.occupied;
    assign o_status.id_match    = (r_rd.order_id == r_item.order_id);
    assign o_status.home        = r_item.order_id[SLOT_W-1:0];
    assign o_status.is_probe_op = (r_item.opcode == OP_CREATE && !o_status.create_bad) ||
                                  r_item.opcode == OP_LOCAL || r_item.opcode == OP_REPORT ||
                                  r_item.opcode == OP_QUERY;
    assign o_status.create_bad  = (r_item.order_id == '0) || r_item.quantity[31] ||
                                  (r_item.quantity == '0) || !r_item.instrument_present;

    assign o_out_valid = r_valid;
    assign o_result    = r_result;
    assign o_account   = r_account;

    always_comb begin
        logic [3:0] b;
        logic [3:0] a;
        logic       cneg;
        logic       cbig;
        logic       sch;
        logic       fch;
        logic       cack;
        logic       rec;
        n_result = '0;
        n_acct   = r_account;
        w_we     = 1'b0;
        w_wdata  = r_rd;
        b        = r_rd.state;
        a        = b;
        cneg     = r_item.cum_fill[31];
        cbig     = r_item.cum_fill[30:0] > r_rd.quantity;
        sch      = 1'b0;
        fch      = 1'b0;
        cack     = r_rd.cancel_ack;
        rec      = r_rd.reconcile;
        case (r_item.opcode)
            OP_CREATE: begin
                if (o_status.create_bad) begin
                    n_acct = 1'b1;
                    n_result.result_code = RC_CONFLICT;
                    n_result.reconcile_needed = 1'b1;
                end else if (i_found) begin
                    n_result.result_code = RC_DUP;
                end else if (!i_have_slot) begin
                    n_acct = 1'b1;
                    n_result.result_code = RC_CAPACITY;
                    n_result.reconcile_needed = 1'b1;
                end else begin
                    w_we = 1'b1;
                    w_wdata.occupied   = 1'b1;
                    w_wdata.order_id   = r_item.order_id;
                    w_wdata.quantity   = r_item.quantity[30:0];
                    w_wdata.state      = ST_CREATED;
                    w_wdata.filled     = '0;
                    w_wdata.cancel_ack = 1'b0;
                    w_wdata.reconcile  = 1'b0;
                    n_result.result_code = RC_APPLIED;
                    n_result.state_moved = 1'b1;
                end
            end
            OP_LOCAL: begin
                if (!i_found) begin
                    n_acct = 1'b1;
                    n_result.result_code = RC_UNKNOWN;
                    n_result.reconcile_needed = 1'b1;
                end else begin
                    case (r_item.local_event)
                        EV_RISK_ACC:  if (b == ST_CREATED) a = ST_RISK_ACC;
                        EV_RISK_REJ:  if (b == ST_CREATED) a = ST_RISK_REJ;
                        EV_SUB_REJ:   if (b == ST_RISK_ACC) a = ST_SUB_REJ;
                        EV_SUB_UNK:   if (b == ST_RISK_ACC) a = ST_SUB_UNK;
                        EV_SUBMITTED: if (b == ST_RISK_ACC) a = ST_SUBMITTED;
                        EV_CXL_REQ: if (b == ST_SUBMITTED || b == ST_ACCEPTED || b == ST_PARTIAL)
                            a = ST_CXL_REQ;
                        default: a = b;
                    endcase
                    if (a == b) begin
                        if (closed_state(b)) begin
                            n_result.result_code = RC_STALE;
                        end else begin
                            n_acct = 1'b1;
                            w_we = 1'b1;
                            w_wdata.reconcile = 1'b1;
                            n_result.result_code = RC_CONFLICT;
                            n_result.reconcile_needed = 1'b1;
                        end
                    end else begin
                        w_we = 1'b1;
                        w_wdata.state = a;
                        if (a == ST_SUB_UNK) begin
                            rec = 1'b1;
                            n_acct = 1'b1;
                        end
                        w_wdata.reconcile = rec;
                        n_result.state_moved = 1'b1;
                        n_result.reconcile_needed = rec;
                    end
                end
            end
            OP_REPORT: begin
                if (!i_found) begin
                    n_acct = 1'b1;
                    n_result.result_code = RC_UNKNOWN;
                    n_result.reconcile_needed = 1'b1;
                end else if (cneg || cbig) begin
                    n_acct = 1'b1;
                    w_we = 1'b1;
                    w_wdata.reconcile = 1'b1;
                    n_result.result_code = RC_CONFLICT;
                    n_result.reconcile_needed = 1'b1;
                end else if (r_item.cum_fill[30:0] < r_rd.filled) begin
                    n_result.result_code = RC_STALE;
                end else begin
                    w_we = 1'b1;
                    w_wdata.filled = r_item.cum_fill[30:0];
                    case (r_item.report_type)
                        RPT_ACCEPTED: if (b == ST_SUBMITTED) a = ST_ACCEPTED;
                        RPT_REJECTED: if (b == ST_SUBMITTED) a = ST_REJECTED;
                        RPT_PARTIAL: if (!closed_state(b) || b == ST_CANCELED) a = ST_PARTIAL;
                        RPT_FILLED: if (r_item.cum_fill[30:0] == r_rd.quantity &&
                                  b != ST_RISK_REJ && b != ST_SUB_REJ) a = ST_FILLED;
                        RPT_CANCELED: if (b != ST_FILLED && b != ST_REJECTED &&
                                  b != ST_RISK_REJ && b != ST_SUB_REJ) begin
                            a = ST_CANCELED;
                            cack = 1'b1;
                        end
                        RPT_CXL_REJ: if (b == ST_CXL_REQ)
                            a = (r_item.cum_fill[30:0] == '0) ? ST_ACCEPTED : ST_PARTIAL;
                        default: a = b;
                    endcase
                    w_wdata.cancel_ack = cack;
                    fch = r_rd.filled != r_item.cum_fill[30:0];
                    sch = a != b;
                    if (!sch && !fch) begin
                        n_result.result_code = RC_DUP;
                    end else if (!sch && r_item.report_type != RPT_ACCEPTED) begin
                        n_acct = 1'b1;
                        w_wdata.reconcile = 1'b1;
                        n_result.result_code = RC_CONFLICT;
                        n_result.reconcile_needed = 1'b1;
                    end else begin
                        w_wdata.state = a;
                        n_result.state_moved = sch;
                        n_result.fill_moved = fch;
                    end
                end
            end
            OP_TRADE: begin
                n_acct = 1'b1;
                n_result.result_code = RC_CONFLICT;
                n_result.reconcile_needed = 1'b1;
            end
            OP_QUERY: begin
                if (!i_found) begin
                    n_result.result_code = RC_UNKNOWN;
                end else begin
                    n_result.order_found       = 1'b1;
                    n_result.order_state       = r_rd.state;
                    n_result.order_qty         = r_rd.quantity;
                    n_result.filled_quantity   = r_rd.filled;
                    n_result.cancel_ack        = r_rd.cancel_ack;
                    n_result.order_reconcile   = r_rd.reconcile;
                end
            end
            default: n_result.result_code = RC_CONFLICT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd) begin
            r_rd     <= mem[i_cmd.addr];
        end
        if (i_cmd.clear) begin
            mem[i_cmd.addr] <= '0;
        end else if (i_cmd.eval && w_we) begin
            mem[i_cmd.addr] <= w_wdata;
        end
        if (i_cmd.eval) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_account <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_account <= n_acct;
                r_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== bench/order_lifecycle_tracker_tb.sv =====
// Self-checking order lifecycle tracker testbench: directed, random, stall and full-table tests.
`timescale 1ns / 100ps
module order_lifecycle_tracker_tb;
    import olt_pkg::*;

    localparam int  ITEMS     = 1000;
    localparam int  MAX_CYCLE = 3000000;
    localparam int  HOLD_LEN  = 400;

    localparam logic [2:0] EV_BAD        = 3'd6;
    localparam logic [2:0] RPT_BAD       = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd5;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        state_moved;
        logic        fill_moved;
        logic        position_changed;
        logic        reconcile_needed;
        logic        order_found;
        logic [3:0]  order_state;
        logic [30:0] order_qty;
        logic [30:0] filled_quantity;
        logic        cancel_ack;
        logic        order_reconcile;
        logic        account_reconcile;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;

    order_lifecycle_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the order book.
    bit          book_used [SLOTS];
    logic [63:0] book_id [SLOTS];
    logic [30:0] book_qty [SLOTS];
    logic [3:0]  book_state [SLOTS];
    logic [30:0] book_filled [SLOTS];
    bit          book_cxl_ack [SLOTS];
    bit          book_recon [SLOTS];
    bit          account_recon;

    t_outcome    pending_results [$];
    logic [63:0] live_ids [$];
    int          errors;
    int          cycles;
    int          beats_sent;
    int          beats_checked;
    int          rx_wait;
    int          rx_hold;
    bit          tx_idle_on;
    bit          rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int find_slot(input logic [63:0] id, input bit want_empty);
        int idx;
        for (int p = 0; p < SLOTS; p++) begin
            idx = int'((id + 64'(p)) % 64'(SLOTS));
            if (!book_used[idx]) return want_empty ? idx : -1;
            if (!want_empty && book_id[idx] == id) return idx;
        end
        return -1;
    endfunction

    function automatic bit state_is_final(input logic [3:0] s);
        return s == ST_RISK_REJ || s == ST_SUB_REJ || s == ST_SUB_UNK ||
               s == ST_CANCELED || s == ST_FILLED || s == ST_REJECTED;
    endfunction

    function automatic t_outcome apply_order_item(input t_item it);
        t_outcome   r;
        int         s;
        int         qty;
        int         cum;
        logic [3:0] b;
        logic [3:0] a;
        logic [30:0] prev;
        r = '0;
        r.result_code = RC_APPLIED;
        qty = $signed(it.quantity);
        cum = $signed(it.cum_fill);
        case (it.opcode)
            OP_CREATE: begin
                if (it.order_id == 0 || qty <= 0 || !it.instrument_present) begin
                    account_recon = 1;
                    r.result_code = RC_CONFLICT;
                    r.reconcile_needed = 1;
                end else if (find_slot(it.order_id, 0) >= 0) begin
                    r.result_code = RC_DUP;
                end else begin
                    s = find_slot(it.order_id, 1);
                    if (s < 0) begin
                        account_recon = 1;
                        r.result_code = RC_CAPACITY;
                        r.reconcile_needed = 1;
                    end else begin
                        book_used[s] = 1;
                        book_id[s] = it.order_id;
                        book_qty[s] = qty[30:0];
                        book_state[s] = ST_CREATED;
                        book_filled[s] = '0;
                        book_cxl_ack[s] = 0;
                        book_recon[s] = 0;
                        r.state_moved = 1;
                    end
                end
            end
            OP_LOCAL, OP_REPORT: begin
                s = find_slot(it.order_id, 0);
                if (s < 0) begin
                    account_recon = 1;
                    r.result_code = RC_UNKNOWN;
                    r.reconcile_needed = 1;
                end else if (it.opcode == OP_LOCAL) begin
                    b = book_state[s];
                    a = b;
                    case (it.local_event)
                        EV_RISK_ACC:  if (b == ST_CREATED) a = ST_RISK_ACC;
                        EV_RISK_REJ:  if (b == ST_CREATED) a = ST_RISK_REJ;
                        EV_SUB_REJ:   if (b == ST_RISK_ACC) a = ST_SUB_REJ;
                        EV_SUB_UNK:   if (b == ST_RISK_ACC) a = ST_SUB_UNK;
                        EV_SUBMITTED: if (b == ST_RISK_ACC) a = ST_SUBMITTED;
                        EV_CXL_REQ:
                            if (b == ST_SUBMITTED || b == ST_ACCEPTED || b == ST_PARTIAL)
                                a = ST_CXL_REQ;
                        default: ;
                    endcase
                    if (a == b) begin
                        if (state_is_final(b)) begin
                            r.result_code = RC_STALE;
                        end else begin
                            account_recon = 1;
                            book_recon[s] = 1;
                            r.result_code = RC_CONFLICT;
                            r.reconcile_needed = 1;
                        end
                    end else begin
                        book_state[s] = a;
                        if (a == ST_SUB_UNK) begin
                            book_recon[s] = 1;
                            account_recon = 1;
                        end
                        r.state_moved = 1;
                        r.reconcile_needed = book_recon[s];
                    end
                end else begin
                    if (cum < 0 || cum > int'(book_qty[s])) begin
                        account_recon = 1;
                        book_recon[s] = 1;
                        r.result_code = RC_CONFLICT;
                        r.reconcile_needed = 1;
                    end else if (cum < int'(book_filled[s])) begin
                        r.result_code = RC_STALE;
                    end else begin
                        prev = book_filled[s];
                        b = book_state[s];
                        a = b;
                        book_filled[s] = cum[30:0];
                        case (it.report_type)
                            RPT_ACCEPTED: if (b == ST_SUBMITTED) a = ST_ACCEPTED;
                            RPT_REJECTED: if (b == ST_SUBMITTED) a = ST_REJECTED;
                            RPT_PARTIAL:
                                if (!state_is_final(b) || b == ST_CANCELED) a = ST_PARTIAL;
                            RPT_FILLED:
                                if (cum == int'(book_qty[s]) && b != ST_RISK_REJ &&
                                    b != ST_SUB_REJ)
                                    a = ST_FILLED;
                            RPT_CANCELED:
                                if (b != ST_FILLED && b != ST_REJECTED && b != ST_RISK_REJ &&
                                    b != ST_SUB_REJ) begin
                                    a = ST_CANCELED;
                                    book_cxl_ack[s] = 1;
                                end
                            RPT_CXL_REJ:
                                if (b == ST_CXL_REQ) a = (cum == 0) ? ST_ACCEPTED : ST_PARTIAL;
                            default: ;
                        endcase
                        r.fill_moved = prev != cum[30:0];
                        r.state_moved = a != b;
                        if (!r.state_moved && !r.fill_moved) begin
                            r.result_code = RC_DUP;
                        end else if (!r.state_moved && it.report_type != RPT_ACCEPTED) begin
                            account_recon = 1;
                            book_recon[s] = 1;
                            r.result_code = RC_CONFLICT;
                            r.reconcile_needed = 1;
                            r.fill_moved = 0;
                        end else begin
                            book_state[s] = a;
                        end
                    end
                end
            end
            OP_TRADE: begin
                account_recon = 1;
                r.result_code = RC_CONFLICT;
                r.reconcile_needed = 1;
            end
            OP_QUERY: begin
                s = find_slot(it.order_id, 0);
                if (s < 0) begin
                    r.result_code = RC_UNKNOWN;
                end else begin
                    r.order_found = 1;
                    r.order_state = book_state[s];
                    r.order_qty = book_qty[s];
                    r.filled_quantity = book_filled[s];
                    r.cancel_ack = book_cxl_ack[s];
                    r.order_reconcile = book_recon[s];
                end
            end
            default: r.result_code = RC_CONFLICT;
        endcase
        r.account_reconcile = account_recon;
        return r;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, it.cum_fill, it.report_type, it.local_event,
                         it.instrument_present, it.quantity, it.order_id, it.opcode};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_order_item(it));
        beats_sent++;
        if (it.opcode == OP_CREATE && find_slot(it.order_id, 0) >= 0 &&
            live_ids.size() < 400)
            live_ids.push_back(it.order_id);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_item make_item(input logic [2:0] op, input logic [63:0] id,
                                        input logic [31:0] qty, input bit instr,
                                        input logic [2:0] ev, input logic [2:0] rt,
                                        input logic [31:0] cum);
        t_item it;
        it.opcode = op;
        it.order_id = id;
        it.quantity = qty;
        it.instrument_present = instr;
        it.local_event = ev;
        it.report_type = rt;
        it.cum_fill = cum;
        return it;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result_code = m_axis_tdata[2:0];
            got.state_moved = m_axis_tdata[3];
            got.fill_moved = m_axis_tdata[4];
            got.position_changed = m_axis_tdata[5];
            got.reconcile_needed = m_axis_tdata[6];
            got.order_found = m_axis_tdata[7];
            got.order_state = m_axis_tdata[11:8];
            got.order_qty = m_axis_tdata[42:12];
            got.filled_quantity = m_axis_tdata[73:43];
            got.cancel_ack = m_axis_tdata[74];
            got.order_reconcile = m_axis_tdata[75];
            got.account_reconcile = m_axis_tdata[76];
            if (pending_results.size() == 0) begin
                $error("Result beat arrived with no expectation pending.");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_code", want.result_code, got.result_code);
                check_field("state_moved", want.state_moved, got.state_moved);
                check_field("fill_moved", want.fill_moved, got.fill_moved);
                check_field("position_changed", want.position_changed, got.position_changed);
                check_field("reconcile_needed", want.reconcile_needed, got.reconcile_needed);
                check_field("order_found", want.order_found, got.order_found);
                check_field("order_state", want.order_state, got.order_state);
                check_field("order_qty", want.order_qty, got.order_qty);
                check_field("filled_quantity", want.filled_quantity, got.filled_quantity);
                check_field("cxl_ack", want.cancel_ack, got.cancel_ack);
                check_field("order_reconcile", want.order_reconcile, got.order_reconcile);
                check_field("account_reconcile", want.account_reconcile,
                            got.account_reconcile);
            end
            beats_checked++;
            rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [63:0] id_a;
        logic [63:0] id_b;
        id_a = 64'hFFFF_FFFF_FFFF_FFFF;
        id_b = id_a - 64'(SLOTS);
        send_item(make_item(OP_CREATE, 64'd0, 32'd5, 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, 64'd7, 32'd0, 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, 64'd7, 32'h8000_0000, 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, 64'd7, 32'd5, 0, 0, 0, 0));
        send_item(make_item(OP_CREATE, id_a, 32'h7FFF_FFFF, 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, id_a, 32'd9, 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, id_b, 32'd10, 1, 0, 0, 0));
        send_item(make_item(OP_LOCAL, id_b, 0, 0, EV_BAD, 0, 0));
        send_item(make_item(OP_LOCAL, id_b, 0, 0, EV_RISK_ACC, 0, 0));
        send_item(make_item(OP_LOCAL, id_b, 0, 0, EV_SUBMITTED, 0, 0));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_ACCEPTED, 32'd0));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_PARTIAL, 32'd4));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_PARTIAL, 32'd2));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_PARTIAL, 32'hFFFF_FFFF));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_BAD, 32'd11));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_BAD, 32'd6));
        send_item(make_item(OP_LOCAL, id_b, 0, 0, EV_CXL_REQ, 0, 0));
        send_item(make_item(OP_REPORT, id_b, 0, 0, 0, RPT_CANCELED, 32'd6));
        send_item(make_item(OP_LOCAL, id_b, 0, 0, EV_RISK_ACC, 0, 0));
        send_item(make_item(OP_QUERY, id_b, 0, 0, 0, 0, 0));
        send_item(make_item(OP_QUERY, 64'd12345, 0, 0, 0, 0, 0));
        send_item(make_item(OP_LOCAL, 64'd12345, 0, 0, EV_RISK_ACC, 0, 0));
        send_item(make_item(OP_TRADE, id_a, 0, 0, 0, 0, 0));
        send_item(make_item(OP_UNUSED, id_a, 0, 0, 0, 0, 0));
        send_item(make_item(3'd7, id_a, 32'hFFFF_FFFF, 1, 3'd7, 3'd7, 32'hFFFF_FFFF));
        wait_all_results();
    endtask

    // Picks a move that an order in the given state would normally see next.
    function automatic t_item lifecycle_step(input logic [63:0] id, input int s);
        t_item it;
        int    q;
        int    f;
        it = make_item(OP_LOCAL, id, $urandom, $urandom_range(0, 1), 0, 0, 0);
        q = int'(book_qty[s]);
        f = int'(book_filled[s]);
        case (book_state[s])
            ST_CREATED:  it.local_event = ($urandom_range(0, 5) == 0) ? EV_RISK_REJ : EV_RISK_ACC;
            ST_RISK_ACC: it.local_event = ($urandom_range(0, 5) != 0) ? EV_SUBMITTED :
                                          ($urandom_range(0, 1) ? EV_SUB_REJ : EV_SUB_UNK);
            ST_SUBMITTED: begin
                it.opcode = OP_REPORT;
                it.report_type = ($urandom_range(0, 7) == 0) ? RPT_REJECTED : RPT_ACCEPTED;
                it.cum_fill = 32'(f);
            end
            ST_ACCEPTED, ST_PARTIAL: begin
                if ($urandom_range(0, 4) == 0) begin
                    it.local_event = EV_CXL_REQ;
                end else begin
                    it.opcode = OP_REPORT;
                    it.report_type = $urandom_range(0, 2) ? RPT_PARTIAL : RPT_FILLED;
                    it.cum_fill = (it.report_type == RPT_FILLED) ? 32'(q) :
                                  32'($urandom_range(f, q));
                end
            end
            ST_CXL_REQ: begin
                it.opcode = OP_REPORT;
                it.report_type = $urandom_range(0, 1) ? RPT_CANCELED : RPT_CXL_REJ;
                it.cum_fill = 32'(f);
            end
            default: begin
                it.opcode = $urandom_range(0, 1) ? OP_LOCAL : OP_REPORT;
                it.local_event = $urandom_range(0, 7);
                it.report_type = $urandom_range(0, 7);
                it.cum_fill = 32'($urandom_range(0, q));
            end
        endcase
        return it;
    endfunction

    task automatic test_random_lifecycles();
        t_item       it;
        logic [63:0] id;
        int          pick;
        int          s;
        for (int n = 0; n < ITEMS; n++) begin
            if (n % 400 == 0) begin
                tx_idle_on = (n % 800 == 0);
                rx_idle_on = (n % 1200 != 0);
            end
            pick = $urandom_range(0, 99);
            id = (live_ids.size() != 0) ? live_ids[$urandom_range(0, live_ids.size() - 1)]
                                        : 64'd1;
            it = make_item(OP_QUERY, id, $urandom, $urandom_range(0, 1), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom);
            if (pick < 12 || live_ids.size() == 0) begin
                it.opcode = OP_CREATE;
                it.instrument_present = ($urandom_range(0, 9) != 0);
                it.quantity = $urandom_range(0, 3) ? 32'($urandom_range(1, 100)) : $urandom;
                case ($urandom_range(0, 3))
                    0: it.order_id = {$urandom, $urandom};
                    1: it.order_id = id + 64'(SLOTS) * $urandom_range(1, 3);
                    2: it.order_id = id;
                    default: it.order_id = 64'($urandom_range(1, 3000));
                endcase
            end else if (pick < 80) begin
                s = find_slot(id, 0);
                it = lifecycle_step(id, s);
            end else if (pick < 88) begin
                it.opcode = OP_QUERY;
                if ($urandom_range(0, 3) == 0) it.order_id = {$urandom, $urandom};
            end else if (pick < 96) begin
                it.opcode = $urandom_range(0, 1) ? OP_LOCAL : OP_REPORT;
                if ($urandom_range(0, 2) == 0) it.order_id = {$urandom, $urandom};
                if ($urandom_range(0, 1)) it.cum_fill = $urandom_range(0, 120);
            end else begin
                it.opcode = $urandom_range(3, 7);
                if (it.opcode == OP_QUERY) it.opcode = OP_TRADE;
            end
            send_item(it);
        end
        tx_idle_on = 1;
        rx_idle_on = 1;
        wait_all_results();
    endtask

    task automatic test_output_stall();
        tx_idle_on = 0;
        rx_hold = HOLD_LEN;
        for (int n = 0; n < 30; n++)
            send_item(make_item(OP_QUERY, live_ids[$urandom_range(0, live_ids.size() - 1)],
                                0, 0, 0, 0, 0));
        tx_idle_on = 1;
        wait_all_results();
    endtask

    task automatic test_full_table();
        for (int h = 0; h < SLOTS; h++)
            if (!book_used[h])
                send_item(make_item(OP_CREATE, 64'(h) + 64'(SLOTS) * $urandom_range(4, 9999),
                                    32'($urandom_range(1, 50)), 1, 0, 0, 0));
        send_item(make_item(OP_CREATE, 64'h0123_4567_89AB_CDEF, 32'd3, 1, 0, 0, 0));
        send_item(make_item(OP_QUERY, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, 0));
        send_item(make_item(OP_REPORT, 64'h0123_4567_89AB_CDEF, 0, 0, 0, RPT_FILLED, 0));
        wait_all_results();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        beats_sent = 0;
        beats_checked = 0;
        rx_wait = 0;
        rx_hold = 0;
        tx_idle_on = 1;
        rx_idle_on = 1;
        account_recon = 0;
        for (int i = 0; i < SLOTS; i++) book_used[i] = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_lifecycles();
        test_output_stall();
        test_full_table();

        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived.", pending_results.size());
            errors++;
        end
        $display("Sent %0d beats and checked %0d results across lifecycles,", beats_sent,
                 beats_checked);
        $display("malformed items, long output stalls and a full order table.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
